// ----- hw/rtl/common_substring_run_finder_top_macros.svh -----
// ----------------------------------------------------------------------------
// common substring run finder assertion macros
// concurrent check helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef COMMON_SUBSTRING_RUN_FINDER_TOP_MACROS_SVH
`define COMMON_SUBSTRING_RUN_FINDER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CSRF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("csrf assertion failed");

// next-cycle implication
`define CSRF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("csrf assertion failed");

`else

`define CSRF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define CSRF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// ----- hw/rtl/csrf_pkg.sv -----
// ----------------------------------------------------------------------------
// csrf_pkg
// shared types and codes of the common substring run finder
// ----------------------------------------------------------------------------
package csrf_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int RUN_LIMIT   = MAX_RESULTS - 1;
    localparam int KW          = $clog2(MAX_RESULTS);

    localparam logic [10:0] COUNT_MAX = 11'd2047;

    localparam logic OP_FIRST     = 1'b0;
    localparam logic OP_SECOND    = 1'b1;
    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [4:0]  start_first;
        logic [4:0]  start_second;
        logic [5:0]  run_length;
        logic [10:0] run_count;
        logic        overflow;
    } csrf_item_t;

    typedef struct packed {
        logic push;
        logic finish;
    } csrf_req_t;

endpackage

// ----- hw/rtl/csrf_out_stage.sv -----
// ----------------------------------------------------------------------------
// csrf_out_stage
// holds the newest result word until the next one or the end of the input
// is known, so that the final word can be marked, then drives the output
// ----------------------------------------------------------------------------
`include "common_substring_run_finder_top_macros.svh"

module csrf_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csrf_pkg::csrf_req_t  req,
    input  csrf_pkg::csrf_item_t item,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 kind,
    output logic [4:0]           start_first,
    output logic [4:0]           start_second,
    output logic [5:0]           run_length,
    output logic [10:0]          run_count,
    output logic                 overflow,
    output logic                 last_result
);
    import csrf_pkg::*;

    csrf_item_t hold_reg;
    logic       hold_valid_reg;
    csrf_item_t out_reg;
    logic       out_last_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       move;

    assign out_free = !out_valid_reg || !out_stall;
    assign room     = !hold_valid_reg || out_free;
    // held word leaves once its successor or the end of the input shows up
    assign move     = hold_valid_reg && room && (req.push || req.finish);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (req.push && room)
                hold_valid_reg <= 1'b1;
            else if (req.finish && room)
                hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= req.finish;
        end
        if (req.push && room)
            hold_reg <= item;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign start_first  = out_reg.start_first;
    assign start_second = out_reg.start_second;
    assign run_length   = out_reg.run_length;
    assign run_count    = out_reg.run_count;
    assign overflow     = out_reg.overflow;
    assign last_result  = out_last_reg;

    `CSRF_ASSERT_NEXT(a_finish_drains, clk, rst_n, req.finish && room, !hold_valid_reg)
    `CSRF_ASSERT_IMPL(a_one_request, clk, rst_n, req.push, !req.finish)
    `CSRF_ASSERT_NEXT(a_move_shows, clk, rst_n, move, out_valid_reg)

endmodule

// ----- hw/rtl/csrf_engine.sv -----
// ----------------------------------------------------------------------------
// csrf_engine
// first string and run column memories with the row walk sequencer
// ----------------------------------------------------------------------------
`include "common_substring_run_finder_top_macros.svh"

module csrf_engine #(
    parameter int MAX_LEN = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [7:0]            ch,
    input  logic                  last,
    input  logic                  room,
    output csrf_pkg::csrf_req_t   req,
    output csrf_pkg::csrf_item_t  item
);
    import csrf_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int WW = (CW > 6) ? CW : 6;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRIME = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [7:0]    fs_mem [MAX_LEN];
    logic [CW-1:0] rc_mem [MAX_LEN];
    logic [7:0]    fs_rd_reg;
    logic [CW-1:0] rc_rd_reg;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] col_reg;
    logic [10:0]   runs_reg;
    logic          ovf_reg;
    logic          cv_reg;
    logic          pass2_reg;
    logic [KW-1:0] k_reg;
    logic [CW-1:0] iss_reg;

    logic [7:0]    ch_reg;
    logic          last_reg;
    logic [AW-1:0] cr_reg;
    logic          match_reg;
    logic [CW-1:0] prev_im1_reg;

    logic          accept;
    logic          len_full;
    logic          col_full;
    logic          col_on;
    logic [CW-1:0] col_after;
    logic          go_pass1;
    logic          pass2_ok;
    logic          issue;
    logic          fs_wr_en;
    logic          fs_rd_en;
    logic [AW-1:0] fs_rd_addr;
    logic          rc_wr_en;
    logic          next_match;
    logic [CW-1:0] prev_i;
    logic [CW-1:0] new_val;
    logic [CW-1:0] run_val;
    logic          want;
    logic          emit;
    logic          adv;
    logic          walk_done;
    logic [WW-1:0] sf_w;
    logic [WW-1:0] ss_w;
    logic [WW-1:0] len_w;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign len_full  = (len_reg == CW'(MAX_LEN));
    assign col_full  = (col_reg == CW'(MAX_LEN));
    assign col_on    = (col_reg != '0);
    assign col_after = col_full ? col_reg : col_reg + CW'(1);
    assign go_pass1  = !col_full && (len_reg != '0);
    assign pass2_ok  = (col_after != '0) && (len_reg != '0);

    // walk pipeline: issue reads of row r, compute row r in the cycle after
    assign issue      = (state_reg == S_WALK) && adv && (iss_reg < len_reg);
    assign fs_wr_en   = accept && (op == OP_FIRST) && !col_on && !len_full;
    assign fs_rd_en   = (state_reg == S_PRIME) || issue;
    assign fs_rd_addr = (state_reg == S_PRIME) ? '0 : iss_reg[AW-1:0] + AW'(1);

    assign next_match = ((CW'(cr_reg) + CW'(1)) < len_reg) && (fs_rd_reg == ch_reg);
    // column zero has no previous column to read
    assign prev_i     = col_on ? rc_rd_reg : '0;
    assign new_val    = match_reg ? prev_im1_reg + CW'(1) : '0;
    assign run_val    = pass2_reg ? rc_rd_reg : prev_i;
    assign want       = cv_reg && (run_val >= CW'(2)) && (pass2_reg || !next_match);
    assign emit       = want && (k_reg != KW'(RUN_LIMIT));
    assign adv        = !(emit && !room);
    assign rc_wr_en   = (state_reg == S_WALK) && cv_reg && adv && !pass2_reg;
    assign walk_done  = (state_reg == S_WALK) && cv_reg && adv
                        && ((CW'(cr_reg) + CW'(1)) == len_reg);

    always_ff @(posedge clk)
    begin
        if (fs_wr_en)
            fs_mem[len_reg[AW-1:0]] <= ch;
        if (fs_rd_en)
            fs_rd_reg <= fs_mem[fs_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rc_wr_en)
            rc_mem[cr_reg] <= new_val;
        if (issue)
            rc_rd_reg <= rc_mem[iss_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_SECOND))
                begin
                    if (go_pass1)
                        state_next = S_PRIME;
                    else if (last)
                        state_next = pass2_ok ? S_PRIME : S_SUM;
                    else
                        state_next = S_FIN;
                end
            end
            S_PRIME:
                state_next = S_WALK;
            S_WALK:
            begin
                if (walk_done)
                begin
                    if (pass2_reg)
                        state_next = S_SUM;
                    else
                        state_next = last_reg ? S_PRIME : S_FIN;
                end
            end
            S_SUM:
                state_next = room ? S_FIN : S_SUM;
            S_FIN:
                state_next = room ? S_IDLE : S_FIN;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            col_reg   <= '0;
            runs_reg  <= '0;
            ovf_reg   <= 1'b0;
            cv_reg    <= 1'b0;
            pass2_reg <= 1'b0;
            k_reg     <= '0;
            iss_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (op == OP_FIRST)
                        begin
                            // first string bytes during a comparison are ignored
                            if (!col_on)
                            begin
                                if (!len_full)
                                    len_reg <= len_reg + CW'(1);
                                else
                                    ovf_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            k_reg     <= '0;
                            pass2_reg <= !go_pass1;
                            if (col_full)
                                ovf_reg <= 1'b1;
                            if (!go_pass1)
                                col_reg <= col_after;
                        end
                    end
                end
                S_PRIME:
                begin
                    iss_reg <= '0;
                    cv_reg  <= 1'b0;
                end
                S_WALK:
                begin
                    if (adv)
                    begin
                        if (issue)
                            iss_reg <= iss_reg + CW'(1);
                        cv_reg <= issue;
                        if (want && (runs_reg != COUNT_MAX))
                            runs_reg <= runs_reg + 11'd1;
                        if (emit)
                            k_reg <= k_reg + KW'(1);
                        if (walk_done && !pass2_reg)
                        begin
                            col_reg   <= col_reg + CW'(1);
                            pass2_reg <= 1'b1;
                        end
                    end
                end
                S_SUM:
                begin
                    cv_reg <= 1'b0;
                end
                S_FIN:
                begin
                    if (room && last_reg)
                    begin
                        len_reg  <= '0;
                        col_reg  <= '0;
                        runs_reg <= '0;
                        ovf_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    cv_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_SECOND))
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
        if ((state_reg == S_WALK) && adv)
        begin
            if (issue)
                cr_reg <= iss_reg[AW-1:0];
            match_reg    <= (fs_rd_reg == ch_reg);
            prev_im1_reg <= cv_reg ? prev_i : '0;
        end
    end

    // run ends at row cr, column col_reg - 1
    assign len_w = WW'(run_val);
    assign sf_w  = WW'(cr_reg) + WW'(1) - len_w;
    assign ss_w  = WW'(col_reg) - len_w;

    always_comb
    begin
        req.push   = ((state_reg == S_WALK) && emit) || (state_reg == S_SUM);
        req.finish = (state_reg == S_FIN);
        item.overflow = ovf_reg;
        if (state_reg == S_SUM)
        begin
            item.kind         = KIND_SUMMARY;
            item.start_first  = '0;
            item.start_second = '0;
            item.run_length   = '0;
            item.run_count    = runs_reg;
        end
        else
        begin
            item.kind         = KIND_RUN;
            item.start_first  = sf_w[4:0];
            item.start_second = ss_w[4:0];
            item.run_length   = len_w[5:0];
            item.run_count    = '0;
        end
    end

    `CSRF_ASSERT_IMPL(a_push_limit, clk, rst_n, req.push && (state_reg == S_WALK), k_reg != KW'(RUN_LIMIT))
    `CSRF_ASSERT_IMPL(a_col_bound, clk, rst_n, 1'b1, col_reg <= CW'(MAX_LEN))
    `CSRF_ASSERT_IMPL(a_wr_row, clk, rst_n, rc_wr_en, (CW'(cr_reg) < len_reg) && col_reg < CW'(MAX_LEN))
    `CSRF_ASSERT_NEXT(a_close_clears, clk, rst_n, (state_reg == S_FIN) && room && last_reg, (len_reg == '0) && (col_reg == '0) && (runs_reg == '0))

endmodule

// ----- hw/rtl/common_substring_run_finder_top.sv -----
// ----------------------------------------------------------------------------
// common_substring_run_finder_top
// diagonal run finder over the match table of two byte strings
// ----------------------------------------------------------------------------
//   channel   handshake              word
//   input     in_valid / in_stall    op, ch, last
//   output    out_valid / out_stall  kind, start_first, start_second,
//                                    run_length, run_count, overflow,
//                                    last_result
//
// a first string byte is stored on accept; the engine stays idle
// a second string byte runs accept, prime, a walk of one row per cycle
// through the run column read port, unless stalled, plus a fill step, and finish
// a closing byte adds a prime and walk for the final column and a summary
// word; no clearing pass after reset
// out_stall freezes the row walk while a result word waits for room
// ----------------------------------------------------------------------------
module common_substring_run_finder_top #(
    parameter int MAX_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [4:0]  start_first,
    output logic [4:0]  start_second,
    output logic [5:0]  run_length,
    output logic [10:0] run_count,
    output logic        overflow,
    output logic        last_result
);
    import csrf_pkg::*;

    csrf_req_t  req;
    csrf_item_t item;
    logic       room;

    csrf_engine #(
        .MAX_LEN (MAX_LEN)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .ch       (ch),
        .last     (last),
        .room     (room),
        .req      (req),
        .item     (item)
    );

    csrf_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .item         (item),
        .room         (room),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .start_first  (start_first),
        .start_second (start_second),
        .run_length   (run_length),
        .run_count    (run_count),
        .overflow     (overflow),
        .last_result  (last_result)
    );

endmodule
